// ----- rtl/core/psq_pkg.sv -----
package psq_pkg;

    // action codes
    localparam logic [3:0] ACT_INS_FRONT = 4'd0;
    localparam logic [3:0] ACT_INS_BACK  = 4'd1;
    localparam logic [3:0] ACT_INS_AT    = 4'd2;
    localparam logic [3:0] ACT_DEL_FRONT = 4'd3;
    localparam logic [3:0] ACT_DEL_BACK  = 4'd4;
    localparam logic [3:0] ACT_DEL_AT    = 4'd5;
    localparam logic [3:0] ACT_SEARCH    = 4'd6;
    localparam logic [3:0] ACT_COUNT     = 4'd7;
    localparam logic [3:0] ACT_DUMP      = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // per-cell load select
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t CELL_HOLD  = 3'd0;
    localparam cell_op_t CELL_LOAD  = 3'd1;
    localparam cell_op_t CELL_LEFT  = 3'd2;
    localparam cell_op_t CELL_RIGHT = 3'd3;
    localparam cell_op_t CELL_HEAD  = 3'd4;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] value;
        logic [4:0]         position;
    } psq_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [4:0]         found_position;
        logic [4:0]         entry_count;
        logic               last;
    } psq_rsp_t;

endpackage

// ----- rtl/core/psq_cell.sv -----
module psq_cell (
    input  logic               clk,
    input  psq_pkg::cell_op_t  op,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] left,
    input  logic signed [31:0] right,
    input  logic signed [31:0] head,
    input  logic signed [31:0] key,
    output logic signed [31:0] q,
    output logic               match
);
    import psq_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        case (op)
            CELL_LOAD:  value_next = load_value;
            CELL_LEFT:  value_next = left;
            CELL_RIGHT: value_next = right;
            CELL_HEAD:  value_next = head;
            default:    value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q     = value_reg;
    assign match = (value_reg == key);

endmodule

// ----- rtl/core/positional_sequence_store.sv -----
// Ordered store of up to DEPTH signed 32-bit entries held in a row of shifting
// cells. An item is taken when start is high and busy is low. Insert, delete,
// count and unused action codes do their work and return to idle, with the
// single result strobed in the cycle after the work cycle; a search compares
// all cells together in its work cycle and encodes the first hit in the next.
// A dump rotates the row one place per cycle and reports the front cell each
// cycle, so the N results of a dump of N entries arrive on consecutive cycles
// and the row ends in its original order. Each result is valid for exactly one
// cycle while strobe is high; the receiver cannot stall,
// so it must take every strobed result. entry_count and found_position are 5
// bits wide and wrap for DEPTH above 31.
module positional_sequence_store #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  psq_pkg::psq_cmd_t cmd,
    output logic              busy,
    output logic              strobe,
    output psq_pkg::psq_rsp_t rsp
);
    import psq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    localparam logic [1:0] ROW_HOLD = 2'd0;
    localparam logic [1:0] ROW_INS  = 2'd1;
    localparam logic [1:0] ROW_DEL  = 2'd2;
    localparam logic [1:0] ROW_ROT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    psq_cmd_t           cmd_reg, cmd_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [IW-1:0]      step_reg, step_next;
    logic [DEPTH-1:0]   hit_reg, hit_next;
    psq_rsp_t           rsp_reg, rsp_next;
    logic               strobe_reg, strobe_next;

    logic [1:0]         row_op;
    logic [IW-1:0]      row_idx;
    logic               emit;
    psq_rsp_t           res;
    logic [PW-1:0]      pos_w;
    logic [PW-1:0]      occ_w;
    logic               full;
    logic               empty;
    logic [DEPTH-1:0]   first_hit;
    logic [IW-1:0]      hit_idx;
    logic [CW-1:0]      hit_pos;
    logic               dump_last;

    cell_op_t           cell_op [DEPTH];
    logic signed [31:0] q       [DEPTH];
    logic signed [31:0] lefts   [DEPTH];
    logic signed [31:0] rights  [DEPTH];
    logic [DEPTH-1:0]   match;
    logic [DEPTH-1:0]   hit;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_row
            localparam logic [IW-1:0] IDX_I = IW'(i);
            localparam logic [CW-1:0] CNT_I = CW'(i);

            if (i == 0)
            begin : g_front
                assign lefts[i] = cmd_reg.value;
            end
            else
            begin : g_mid_l
                assign lefts[i] = q[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_back
                assign rights[i] = q[i];
            end
            else
            begin : g_mid_r
                assign rights[i] = q[i+1];
            end

            always_comb
            begin
                cell_op[i] = CELL_HOLD;
                case (row_op)
                    ROW_INS:
                    begin
                        if (IDX_I == row_idx)
                            cell_op[i] = CELL_LOAD;
                        else if (IDX_I > row_idx && CNT_I <= occ_reg)
                            cell_op[i] = CELL_LEFT;
                    end
                    ROW_DEL:
                    begin
                        if (IDX_I >= row_idx && (CNT_I + CW'(1)) < occ_reg)
                            cell_op[i] = CELL_RIGHT;
                    end
                    ROW_ROT:
                    begin
                        if ((CNT_I + CW'(1)) == occ_reg)
                            cell_op[i] = CELL_HEAD;
                        else if ((CNT_I + CW'(1)) < occ_reg)
                            cell_op[i] = CELL_RIGHT;
                    end
                    default:
                        cell_op[i] = CELL_HOLD;
                endcase
            end

            assign hit[i] = match[i] && (CNT_I < occ_reg);

            psq_cell u_cell (
                .clk        (clk),
                .op         (cell_op[i]),
                .load_value (cmd_reg.value),
                .left       (lefts[i]),
                .right      (rights[i]),
                .head       (q[0]),
                .key        (cmd_reg.value),
                .q          (q[i]),
                .match      (match[i])
            );
        end
    endgenerate

    assign pos_w = PW'(cmd_reg.position);
    assign occ_w = PW'(occ_reg);
    assign full  = (occ_reg == CW'(DEPTH));
    assign empty = (occ_reg == '0);

    // isolate the lowest set bit, then encode its index
    assign first_hit = hit_reg & (~hit_reg + DEPTH'(1));

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first_hit[k])
                hit_idx = hit_idx | IW'(k);
        end
    end

    assign hit_pos   = CW'(hit_idx) + CW'(1);
    assign dump_last = ((CW'(step_reg) + CW'(1)) == occ_reg);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        occ_next   = occ_reg;
        step_next  = step_reg;
        hit_next   = hit_reg;
        row_op     = ROW_HOLD;
        row_idx    = '0;
        emit       = 1'b0;
        res        = '0;
        res.status = ST_OK;
        res.last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                emit       = 1'b1;
                unique case (cmd_reg.action) inside
                    ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                    begin
                        if (full)
                            res.status = ST_FULL;
                        else if (cmd_reg.action == ACT_INS_AT &&
                                 (pos_w == '0 || pos_w > occ_w + PW'(1)))
                            res.status = ST_BADPOS;
                        else
                        begin
                            row_op   = ROW_INS;
                            occ_next = occ_reg + CW'(1);
                            if (cmd_reg.action == ACT_INS_FRONT)
                                row_idx = '0;
                            else if (cmd_reg.action == ACT_INS_BACK)
                                row_idx = IW'(occ_reg);
                            else
                                row_idx = IW'(pos_w - PW'(1));
                        end
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
                    begin
                        if (empty)
                            res.status = ST_EMPTY;
                        else if (cmd_reg.action == ACT_DEL_AT &&
                                 (pos_w == '0 || pos_w > occ_w))
                            res.status = ST_BADPOS;
                        else
                        begin
                            row_op   = ROW_DEL;
                            occ_next = occ_reg - CW'(1);
                            if (cmd_reg.action == ACT_DEL_FRONT)
                                row_idx = '0;
                            else if (cmd_reg.action == ACT_DEL_BACK)
                                row_idx = IW'(occ_reg - CW'(1));
                            else
                                row_idx = IW'(pos_w - PW'(1));
                            res.data = q[row_idx];
                        end
                    end
                    ACT_SEARCH:
                    begin
                        if (empty)
                            res.status = ST_EMPTY;
                        else
                        begin
                            // hold compare hits, encode next cycle
                            emit       = 1'b0;
                            hit_next   = hit;
                            state_next = S_FIND;
                        end
                    end
                    ACT_COUNT:
                        res.status = ST_OK;
                    ACT_DUMP:
                    begin
                        if (empty)
                            res.status = ST_EMPTY;
                        else
                        begin
                            emit       = 1'b0;
                            step_next  = '0;
                            state_next = S_DUMP;
                        end
                    end
                    default:
                        res.status = ST_OK;
                endcase
            end
            S_FIND:
            begin
                state_next = S_IDLE;
                emit       = 1'b1;
                if (|hit_reg)
                    res.found_position = 5'(hit_pos);
                else
                    res.status = ST_NOTFOUND;
            end
            S_DUMP:
            begin
                // report the front cell and rotate it to the back
                row_op   = ROW_ROT;
                emit     = 1'b1;
                res.data = q[0];
                res.last = dump_last;
                if (dump_last)
                    state_next = S_IDLE;
                else
                    step_next = step_reg + IW'(1);
            end
            default:
                state_next = S_IDLE;
        endcase

        res.entry_count = 5'(occ_next);
        strobe_next     = emit;
        rsp_next        = emit ? res : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        step_reg <= step_next;
        hit_reg  <= hit_next;
        rsp_reg  <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

endmodule

// ----- tb/sv/psq_checker.sv -----
`timescale 1ns / 100ps

module psq_checker #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  psq_pkg::psq_cmd_t cmd,
    input  logic              strobe,
    input  psq_pkg::psq_rsp_t rsp,
    output int                errors,
    output int                outstanding,
    output int                fill_level
);
    import psq_pkg::*;

    logic signed [31:0] cells [DEPTH];
    int                 occupancy;
    int                 faults;
    psq_rsp_t           awaited_replies [$];

    // entry_count always reflects the store after the action
    function automatic psq_rsp_t make_reply(input logic [2:0] st, input logic signed [31:0] d,
                                            input int fpos, input logic fin);
        psq_rsp_t r;
        r.status         = st;
        r.data           = d;
        r.found_position = 5'(fpos);
        r.entry_count    = 5'(occupancy);
        r.last           = fin;
        return r;
    endfunction

    task automatic apply_action(input psq_cmd_t c);
        int                 slot;
        int                 i;
        int                 hit;
        logic signed [31:0] taken;
        slot = -1;
        hit  = 0;
        case (c.action) inside
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                // full wins over a bad position
                if (occupancy >= DEPTH)
                begin
                    awaited_replies.push_back(make_reply(ST_FULL, '0, 0, 1'b1));
                end
                else
                begin
                    if (c.action == ACT_INS_FRONT)
                        slot = 0;
                    else if (c.action == ACT_INS_BACK)
                        slot = occupancy;
                    else if (int'(c.position) >= 1 && int'(c.position) <= occupancy + 1)
                        slot = int'(c.position) - 1;
                    if (slot < 0)
                    begin
                        awaited_replies.push_back(make_reply(ST_BADPOS, '0, 0, 1'b1));
                    end
                    else
                    begin
                        for (i = occupancy; i > slot; i--)
                            cells[i] = cells[i - 1];
                        cells[slot] = c.value;
                        occupancy++;
                        awaited_replies.push_back(make_reply(ST_OK, '0, 0, 1'b1));
                    end
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
            begin
                if (occupancy == 0)
                begin
                    awaited_replies.push_back(make_reply(ST_EMPTY, '0, 0, 1'b1));
                end
                else
                begin
                    if (c.action == ACT_DEL_FRONT)
                        slot = 0;
                    else if (c.action == ACT_DEL_BACK)
                        slot = occupancy - 1;
                    else if (int'(c.position) >= 1 && int'(c.position) <= occupancy)
                        slot = int'(c.position) - 1;
                    if (slot < 0)
                    begin
                        awaited_replies.push_back(make_reply(ST_BADPOS, '0, 0, 1'b1));
                    end
                    else
                    begin
                        taken = cells[slot];
                        for (i = slot; i + 1 < occupancy; i++)
                            cells[i] = cells[i + 1];
                        occupancy--;
                        awaited_replies.push_back(make_reply(ST_OK, taken, 0, 1'b1));
                    end
                end
            end
            ACT_SEARCH:
            begin
                if (occupancy == 0)
                begin
                    awaited_replies.push_back(make_reply(ST_EMPTY, '0, 0, 1'b1));
                end
                else
                begin
                    for (i = 0; i < occupancy && hit == 0; i++)
                        if (cells[i] == c.value)
                            hit = i + 1;
                    if (hit != 0)
                        awaited_replies.push_back(make_reply(ST_OK, '0, hit, 1'b1));
                    else
                        awaited_replies.push_back(make_reply(ST_NOTFOUND, '0, 0, 1'b1));
                end
            end
            ACT_DUMP:
            begin
                if (occupancy == 0)
                begin
                    awaited_replies.push_back(make_reply(ST_EMPTY, '0, 0, 1'b1));
                end
                else
                begin
                    for (i = 0; i < occupancy; i++)
                        awaited_replies.push_back(make_reply(ST_OK, cells[i], 0,
                                                             i == occupancy - 1));
                end
            end
            // count and the unused codes answer the same way
            default:
            begin
                awaited_replies.push_back(make_reply(ST_OK, '0, 0, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        psq_rsp_t want;
        if (!rst_n)
        begin
            occupancy = 0;
            faults    = 0;
            awaited_replies.delete();
            errors      <= 0;
            outstanding <= 0;
            fill_level  <= 0;
        end
        else
        begin
            if (start && !busy)
                apply_action(cmd);
            if (strobe)
            begin
                if (awaited_replies.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected result status=%0d data=%0d ",
                                 $realtime, rsp.status, rsp.data,
                                 "fpos=%0d count=%0d last=%0b",
                                 rsp.found_position, rsp.entry_count, rsp.last);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp.status !== want.status || rsp.data !== want.data
                        || rsp.found_position !== want.found_position
                        || rsp.entry_count !== want.entry_count || rsp.last !== want.last)
                    begin
                        faults++;
                        if (faults <= 10)
                        begin
                            $display("%0t: mismatch expected status=%0d data=%0d ",
                                     $realtime, want.status, want.data,
                                     "fpos=%0d count=%0d last=%0b",
                                     want.found_position, want.entry_count, want.last);
                            $display("%0t:          got      status=%0d data=%0d ",
                                     $realtime, rsp.status, rsp.data,
                                     "fpos=%0d count=%0d last=%0b",
                                     rsp.found_position, rsp.entry_count, rsp.last);
                        end
                    end
                end
            end
            errors      <= faults;
            outstanding <= awaited_replies.size();
            fill_level  <= occupancy;
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import psq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int PHASE_ITEMS    = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    psq_cmd_t cmd   = '0;
    logic     busy;
    logic     strobe;
    psq_rsp_t rsp;

    int errors;
    int outstanding;
    int fill_level;
    int idle_pct     = 0;
    int issued       = 0;
    int stall_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    positional_sequence_store #(
        .DEPTH(DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .strobe(strobe),
        .rsp   (rsp)
    );

    psq_checker #(
        .DEPTH(DEPTH)
    ) store_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .strobe     (strobe),
        .rsp        (rsp),
        .errors     (errors),
        .outstanding(outstanding),
        .fill_level (fill_level)
    );

    // restart the count on any item or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("positional_sequence_store verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // hold start high after acceptance so back-to-back items need no extra edge
    task automatic issue(input logic [3:0] act, input logic signed [31:0] val,
                         input logic [4:0] pos);
        psq_cmd_t c;
        c.action   = act;
        c.value    = val;
        c.position = pos;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (act <= ACT_DUMP)
            issued++;
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // stop sending until every pending result has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_position(input int limit);
        if ($urandom_range(4) == 0)
            return 5'($urandom_range(31));
        return 5'($urandom_range(1, limit));
    endfunction

    task automatic fill_up();
        logic [3:0] act;
        while (fill_level < DEPTH)
        begin
            act = 4'($urandom_range(ACT_INS_AT));
            issue(act, pick_value(), 5'($urandom_range(1, fill_level + 1)));
            idle_gap();
        end
        issue(ACT_INS_AT, pick_value(), 5'd31);
        issue(ACT_COUNT, pick_value(), 5'($urandom_range(31)));
        issue(ACT_SEARCH, pick_value(), 5'($urandom_range(31)));
        issue(ACT_DUMP, pick_value(), 5'($urandom_range(31)));
    endtask

    task automatic drain_out();
        logic [3:0] act;
        while (fill_level > 0)
        begin
            act = 4'($urandom_range(ACT_DEL_FRONT, ACT_DEL_AT));
            issue(act, pick_value(), 5'($urandom_range(1, fill_level)));
            idle_gap();
        end
        issue(4'($urandom_range(ACT_DEL_FRONT, ACT_DEL_AT)), pick_value(), 5'd0);
        issue(ACT_DUMP, pick_value(), 5'($urandom_range(31)));
    endtask

    task automatic random_op();
        logic [3:0] act;
        logic [4:0] pos;
        if ($urandom_range(99) < 4)
            act = 4'($urandom_range(9, 15));
        else
            act = 4'($urandom_range(ACT_DUMP));
        if (act == ACT_INS_AT)
            pos = pick_position(fill_level + 1);
        else if (act == ACT_DEL_AT)
            pos = pick_position(fill_level);
        else
            pos = 5'($urandom_range(31));
        issue(act, pick_value(), pos);
    endtask

    task automatic random_phase(input int quota);
        int target;
        int pick;
        target = issued + quota;
        fill_up();
        while (issued < target)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                drain_out();
            else if (pick == 1)
                fill_up();
            else if (pick == 2)
                settle();
            else
                random_op();
            idle_gap();
        end
        settle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 12;
        // empty store: every kind of miss
        issue(ACT_DEL_FRONT, 32'sd7, 5'd1);
        issue(ACT_DEL_BACK, 32'sd7, 5'd1);
        issue(ACT_DEL_AT, 32'sd7, 5'd1);
        issue(ACT_SEARCH, 32'sd0, 5'd0);
        issue(ACT_DUMP, 32'sd0, 5'd0);
        issue(ACT_COUNT, 32'sh7FFF_FFFF, 5'd31);
        issue(ACT_INS_AT, 32'sd1, 5'd0);
        issue(ACT_INS_AT, 32'sd1, 5'd2);
        // build a short row with the value extremes
        issue(ACT_INS_AT, 32'sh8000_0000, 5'd1);
        issue(ACT_INS_FRONT, 32'sh7FFF_FFFF, 5'd0);
        issue(ACT_INS_BACK, -32'sd1, 5'd31);
        issue(ACT_INS_AT, 32'sd0, 5'd4);
        issue(ACT_INS_AT, 32'sd5, 5'd2);
        issue(ACT_SEARCH, -32'sd1, 5'd0);
        issue(ACT_SEARCH, 32'sd1234, 5'd0);
        issue(ACT_DEL_AT, 32'sd0, 5'd0);
        issue(ACT_DEL_AT, 32'sd0, 5'd6);
        issue(ACT_DEL_AT, 32'sd0, 5'd3);
        issue(ACT_DUMP, 32'sd0, 5'd0);
        issue(4'd9, 32'sh5A5A_5A5A, 5'd3);
        issue(4'd15, -32'sd1, 5'd31);
        issue(ACT_DEL_BACK, 32'sd0, 5'd0);
        issue(ACT_DEL_FRONT, 32'sd0, 5'd0);
        issue(ACT_DEL_AT, 32'sd0, 5'd2);
        // removing the only entry
        issue(ACT_DEL_FRONT, 32'sd0, 5'd0);
        settle();

        issued = 0;
        random_phase(PHASE_ITEMS);
        idle_pct = 76;
        random_phase(PHASE_ITEMS);
        idle_pct = 0;
        random_phase(PHASE_ITEMS);

        settle();
        repeat (24) @(posedge clk);
        if (errors == 0)
            $display("positional_sequence_store verification clean");
        else
            $display("positional_sequence_store verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/psq_pkg.sv
rtl/core/psq_cell.sv
rtl/core/positional_sequence_store.sv
tb/sv/psq_checker.sv
tb/sv/tb.sv
